// File: rtl/pttu_pkg.sv
// Package for the piston throw and RPM tracker: field widths, fixed tuning
// constants, register indexes, sequencer states. No dependencies.
`default_nettype none
package pttu_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RPM_W  = 24;
  localparam int unsigned THR_W  = 23;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned PER_W  = 20;

  localparam logic [TIME_W-1:0] HALF_CYCLE_MIN_MS = 32'd20;
  localparam logic [TIME_W-1:0] HALF_CYCLE_MAX_MS = 32'd3000;
  localparam logic [TIME_W-1:0] DECAY_TIMEOUT_MS  = 32'd1500;
  localparam logic [23:0]       RPM_MIN_Q         = 24'd2560;
  localparam logic [23:0]       RPM_SCALE         = 24'd15360000;
  localparam logic [23:0]       DECAY_FACTOR_Q16  = 24'd62259;
  localparam logic [RPM_W-1:0]  DECAY_FLOOR_Q     = 24'd256;

  typedef enum logic [1:0] {
    SIDE_UNKNOWN = 2'd0,
    SIDE_ABOVE   = 2'd1,
    SIDE_BELOW   = 2'd2
  } side_e;

  typedef enum logic [2:0] {
    CFG_MOTION_DELTA_MIN  = 3'd0,
    CFG_MINMAX_HYST       = 3'd1,
    CFG_THROW_MIN         = 3'd2,
    CFG_THROW_MAX         = 3'd3,
    CFG_THROW_VALID_MIN   = 3'd4,
    CFG_EMA_ALPHA         = 3'd5,
    CFG_MOTION_TIMEOUT_MS = 3'd6,
    CFG_RPM_MAX           = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOT, ST_WR, ST_RD, ST_CMP, ST_HYST, ST_THROW, ST_SIDE,
    ST_CROSS, ST_NUM, ST_LO, ST_HI, ST_CHK, ST_DIV, ST_EMA0, ST_EMA1,
    ST_EMA2, ST_DEC0, ST_DEC1, ST_DONE
  } state_e;

endpackage
`default_nettype wire

// File: rtl/pttu_in_if.sv
// Input channel of the tracker: valid/ready plus one sample or decay item.
// Depends on pttu_pkg for field widths.
`default_nettype none
interface pttu_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [pttu_pkg::POS_W-1:0]    position;
  logic [pttu_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, func, position, time_ms, input ready);
  modport sink   (input valid, func, position, time_ms, output ready);
endinterface
`default_nettype wire

// File: rtl/pttu_out_if.sv
// Output channel of the tracker: valid/ready plus one result item.
// Depends on pttu_pkg for field widths.
`default_nettype none
interface pttu_out_if;
  logic                          valid;
  logic                          ready;
  logic [pttu_pkg::RPM_W-1:0]    rpm;
  logic [pttu_pkg::THR_W-1:0]    throw;
  logic                          throw_ok;
  logic                          in_motion;
  logic [pttu_pkg::POS_W-1:0]    min_position;
  logic [pttu_pkg::POS_W-1:0]    max_position;

  modport source (output valid, rpm, throw, throw_ok, in_motion, min_position,
                  max_position, input ready);
  modport sink   (input valid, rpm, throw, throw_ok, in_motion, min_position,
                  max_position, output ready);
endinterface
`default_nettype wire

// File: rtl/pttu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pttu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/piston_throw_rpm_tracker_unit.sv
// Top level of the piston throw and RPM tracker: sequencer, shared multiplier,
// bit-serial divider. Depends on pttu_pkg, pttu_in_if, pttu_out_if, pttu_ram.
//
//  channel  dir  handshake            payload
//  in_i     in   valid/ready          func, position, time_ms
//  out_o    out  valid/ready          rpm, throw, throw_ok, in_motion, min/max
//  cfg      in   cfg_we_i (no ready)  cfg_idx_i, cfg_data_i
//
// A moving sample scans the window, each entry through the RAM read port in a
// read and a compare state; a counted crossing adds up to five products on the
// shared multiplier and a divider that retires one quotient bit per cycle over
// NUM_W+1 bits. in_i.ready is high only in idle; the result sits in an output
// register, so the next item is taken while a result still waits. Reset clears
// control and tracking state at once; no clearing pass.
`default_nettype none
module piston_throw_rpm_tracker_unit #(
  parameter int unsigned POSITION_WINDOW_DEPTH = 8,
  parameter int unsigned PERIOD_WINDOW_DEPTH   = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_idx_i,
  input  wire logic [pttu_pkg::CFG_W-1:0]    cfg_data_i,
  pttu_in_if.sink                            in_i,
  pttu_out_if.source                         out_o
);
  localparam int unsigned PW    = POSITION_WINDOW_DEPTH;
  localparam int unsigned PD    = PERIOD_WINDOW_DEPTH;
  localparam int unsigned PA_W  = $clog2(PW);
  localparam int unsigned PF_W  = $clog2(PW + 1);
  localparam int unsigned PH_W  = (PD > 1) ? $clog2(PD) : 1;
  localparam int unsigned DF_W  = $clog2(PD + 1);
  localparam int unsigned TOT_W = pttu_pkg::PER_W + DF_W;
  localparam int unsigned MA_W  = (TOT_W > 24) ? TOT_W : 24;
  localparam int unsigned PROD_W = MA_W + 24;
  localparam int unsigned NUM_W = 24 + DF_W;
  localparam int unsigned DVD_W = NUM_W + 1;
  localparam int unsigned DC_W  = $clog2(DVD_W + 1);
  localparam int unsigned ACC_W = 42;

  // configuration
  logic [15:0] mdm_q, hyst_q, alpha_q, tmo_q;
  logic [22:0] tmin_q, tmax_q, tvmin_q;
  logic [23:0] rmax_q;

  // tracking state
  pttu_pkg::state_e state_q, state_d;
  logic [23:0]      prev_q, prev_d, hmin_q, hmin_d, hmax_q, hmax_d;
  logic             moving_q, moving_d, thr_ok_q, thr_ok_d, started_q, started_d;
  logic [31:0]      lmot_q, lmot_d, lcross_q, lcross_d, lrpm_q, lrpm_d;
  logic [PF_W-1:0]  pfill_q, pfill_d;
  logic [PA_W-1:0]  phead_q, phead_d;
  logic [22:0]      thr_q, thr_d;
  logic [1:0]       side_q, side_d;
  logic [DF_W-1:0]  dfill_q, dfill_d;
  logic [PH_W-1:0]  dhead_q, dhead_d;
  logic [TOT_W-1:0] tot_q, tot_d;
  logic [23:0]      rpm_q, rpm_d;
  logic [19:0]      per_q [PD];
  logic             per_we;
  logic [19:0]      per_v;

  // per-item working registers
  logic [23:0]      pos_q, wmax_q, wmax_d, wmin_q, wmin_d;
  logic [31:0]      now_q, half_q, half_d;
  logic [PF_W-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DVD_W-1:0] dq_q, dq_d;
  logic [TOT_W-1:0] rem_q, rem_d;
  logic [DC_W-1:0]  dcnt_q, dcnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [MA_W-1:0]  mul_a;
  logic [23:0]      mul_b;

  // output register
  logic        ovalid_q, ovalid_d, oload;
  logic [23:0] orpm_q, omin_q, omax_q;
  logic [22:0] othr_q;
  logic        ook_q, omot_q;

  // window RAM
  logic            ram_we;
  logic [23:0]     ram_rdata;

  pttu_ram #(.WIDTH(24), .DEPTH(PW)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (phead_q),
    .wdata_i (pos_q),
    .raddr_i (cnt_q[PA_W-1:0]),
    .rdata_o (ram_rdata)
  );

  logic accept;
  assign in_i.ready = (state_q == pttu_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // datapath helpers
  logic signed [24:0] mot_diff, hx_diff, hn_diff, span;
  logic [24:0]        mot_abs, hx_abs, hn_abs;
  logic signed [25:0] span26;
  logic signed [26:0] twop27, sum27, band27;
  logic [1:0]         side_new;
  logic [TOT_W:0]     rem_sh;
  logic               div_ge;
  logic [ACC_W-1:0]   ema_sum;
  logic [25:0]        ema_sh;

  assign mot_diff = $signed({pos_q[23], pos_q}) - $signed({prev_q[23], prev_q});
  assign mot_abs  = mot_diff[24] ? 25'(-mot_diff) : 25'(mot_diff);
  assign hx_diff  = $signed({wmax_q[23], wmax_q}) - $signed({hmax_q[23], hmax_q});
  assign hx_abs   = hx_diff[24] ? 25'(-hx_diff) : 25'(hx_diff);
  assign hn_diff  = $signed({wmin_q[23], wmin_q}) - $signed({hmin_q[23], hmin_q});
  assign hn_abs   = hn_diff[24] ? 25'(-hn_diff) : 25'(hn_diff);
  assign span     = $signed({hmax_q[23], hmax_q}) - $signed({hmin_q[23], hmin_q});
  assign span26   = {span[24], span};
  assign twop27   = {{2{pos_q[23]}}, pos_q, 1'b0};
  assign sum27    = $signed({{3{hmax_q[23]}}, hmax_q}) + $signed({{3{hmin_q[23]}}, hmin_q});
  assign band27   = {11'd0, hyst_q};
  assign rem_sh   = {rem_q, dq_q[DVD_W-1]};
  assign div_ge   = rem_sh >= {1'b0, tot_q};
  assign ema_sum  = acc_q + ACC_W'(prod_q) + ACC_W'(32768);
  assign ema_sh   = ema_sum[41:16];
  assign prod_d   = mul_a * mul_b;

  always_comb begin
    if (twop27 > sum27 + band27) begin
      side_new = pttu_pkg::SIDE_ABOVE;
    end else if (twop27 < sum27 - band27) begin
      side_new = pttu_pkg::SIDE_BELOW;
    end else begin
      side_new = pttu_pkg::SIDE_UNKNOWN;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      pttu_pkg::ST_NUM:  begin mul_a = MA_W'(dfill_q); mul_b = pttu_pkg::RPM_SCALE; end
      pttu_pkg::ST_LO:   begin mul_a = MA_W'(tot_q);   mul_b = pttu_pkg::RPM_MIN_Q; end
      pttu_pkg::ST_HI:   begin mul_a = MA_W'(tot_q);   mul_b = rmax_q; end
      pttu_pkg::ST_EMA0: begin
        mul_a = MA_W'(rpm_q);
        mul_b = 24'(17'h10000 - {1'b0, alpha_q});
      end
      pttu_pkg::ST_EMA1: begin mul_a = MA_W'(dq_q[23:0]); mul_b = {8'd0, alpha_q}; end
      pttu_pkg::ST_DEC0: begin mul_a = MA_W'(rpm_q); mul_b = pttu_pkg::DECAY_FACTOR_Q16; end
      default: begin end
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    prev_d   = prev_q;   hmin_d = hmin_q;   hmax_d = hmax_q;
    moving_d = moving_q; thr_ok_d = thr_ok_q; started_d = started_q;
    lmot_d   = lmot_q;   lcross_d = lcross_q; lrpm_d = lrpm_q;
    pfill_d  = pfill_q;  phead_d = phead_q;  thr_d = thr_q;  side_d = side_q;
    dfill_d  = dfill_q;  dhead_d = dhead_q;  tot_d = tot_q;  rpm_d = rpm_q;
    wmax_d   = wmax_q;   wmin_d = wmin_q;   half_d = half_q; cnt_d = cnt_q;
    num_d    = num_q;    dq_d = dq_q;       rem_d = rem_q;   dcnt_d = dcnt_q;
    acc_d    = acc_q;
    ram_we   = 1'b0;
    per_we   = 1'b0;
    per_v    = {half_q[18:0], 1'b0};
    oload    = 1'b0;

    unique case (state_q)
      pttu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = in_i.func ? pttu_pkg::ST_DEC0 : pttu_pkg::ST_MOT;
        end
      end
      pttu_pkg::ST_MOT: begin
        prev_d = pos_q;
        if (mot_abs > {9'd0, mdm_q}) begin
          moving_d = 1'b1;
          lmot_d   = now_q;
          state_d  = pttu_pkg::ST_WR;
        end else begin
          if (moving_q && ((now_q - lmot_q) > {16'd0, tmo_q})) begin
            // motion timeout: drop all tracking state
            dfill_d = '0; dhead_d = '0; tot_d = '0;
            pfill_d = '0; phead_d = '0;
            moving_d = 1'b0;
            hmin_d = pos_q; hmax_d = pos_q;
            thr_d = '0; thr_ok_d = 1'b0;
            lcross_d = '0; lrpm_d = '0;
            started_d = 1'b0; rpm_d = '0;
            side_d = pttu_pkg::SIDE_UNKNOWN;
          end
          state_d = pttu_pkg::ST_DONE;
        end
      end
      pttu_pkg::ST_WR: begin
        ram_we  = 1'b1;
        phead_d = (phead_q == PA_W'(PW - 1)) ? '0 : PA_W'(phead_q + 1'b1);
        if (pfill_q < PF_W'(PW)) begin
          pfill_d = PF_W'(pfill_q + 1'b1);
        end
        cnt_d   = '0;
        state_d = pttu_pkg::ST_RD;
      end
      pttu_pkg::ST_RD: begin
        state_d = pttu_pkg::ST_CMP;
      end
      pttu_pkg::ST_CMP: begin
        if (cnt_q == '0) begin
          wmax_d = ram_rdata;
          wmin_d = ram_rdata;
        end else begin
          if ($signed(ram_rdata) > $signed(wmax_q)) wmax_d = ram_rdata;
          if ($signed(ram_rdata) < $signed(wmin_q)) wmin_d = ram_rdata;
        end
        cnt_d   = PF_W'(cnt_q + 1'b1);
        state_d = (PF_W'(cnt_q + 1'b1) == pfill_q) ? pttu_pkg::ST_HYST : pttu_pkg::ST_RD;
      end
      pttu_pkg::ST_HYST: begin
        if (hx_abs > {9'd0, hyst_q}) hmax_d = wmax_q;
        if (hn_abs > {9'd0, hyst_q}) hmin_d = wmin_q;
        state_d = pttu_pkg::ST_THROW;
      end
      pttu_pkg::ST_THROW: begin
        if (span26 < $signed({2'b00, tmin_q, 1'b0})) begin
          thr_d = '0; thr_ok_d = 1'b0;
        end else if (span26 > $signed({2'b00, tmax_q, 1'b0})) begin
          // span too wide: restart the window around this sample
          hmax_d = pos_q; hmin_d = pos_q;
          pfill_d = '0; phead_d = '0;
          thr_d = '0; thr_ok_d = 1'b0;
        end else begin
          thr_d    = span[23:1];
          thr_ok_d = span26 >= $signed({2'b00, tvmin_q, 1'b0});
        end
        state_d = pttu_pkg::ST_SIDE;
      end
      pttu_pkg::ST_SIDE: begin
        state_d = pttu_pkg::ST_DONE;
        if (side_new != pttu_pkg::SIDE_UNKNOWN && side_new != side_q && thr_ok_q) begin
          half_d   = now_q - lcross_q;
          lcross_d = now_q;
          side_d   = side_new;
          if (lcross_q != '0) state_d = pttu_pkg::ST_CROSS;
        end
      end
      pttu_pkg::ST_CROSS: begin
        if (half_q <= pttu_pkg::HALF_CYCLE_MIN_MS || half_q >= pttu_pkg::HALF_CYCLE_MAX_MS) begin
          state_d = pttu_pkg::ST_DONE;
        end else begin
          per_we = 1'b1;
          if (dfill_q >= DF_W'(PD)) begin
            tot_d = TOT_W'(tot_q - TOT_W'(per_q[dhead_q]) + TOT_W'(per_v));
          end else begin
            dfill_d = DF_W'(dfill_q + 1'b1);
            tot_d   = TOT_W'(tot_q + TOT_W'(per_v));
          end
          dhead_d = (dhead_q == PH_W'(PD - 1)) ? '0 : PH_W'(dhead_q + 1'b1);
          state_d = pttu_pkg::ST_NUM;
        end
      end
      pttu_pkg::ST_NUM: begin
        state_d = (tot_q == '0) ? pttu_pkg::ST_DONE : pttu_pkg::ST_LO;
      end
      pttu_pkg::ST_LO: begin
        num_d   = prod_q[NUM_W-1:0];
        state_d = pttu_pkg::ST_HI;
      end
      pttu_pkg::ST_HI: begin
        state_d = (PROD_W'(num_q) > prod_q) ? pttu_pkg::ST_CHK : pttu_pkg::ST_DONE;
      end
      pttu_pkg::ST_CHK: begin
        if (PROD_W'(num_q) < prod_q) begin
          dq_d    = DVD_W'(num_q) + DVD_W'(tot_q >> 1);
          rem_d   = '0;
          dcnt_d  = DC_W'(DVD_W);
          state_d = pttu_pkg::ST_DIV;
        end else begin
          state_d = pttu_pkg::ST_DONE;
        end
      end
      pttu_pkg::ST_DIV: begin
        rem_d  = div_ge ? TOT_W'(rem_sh - {1'b0, tot_q}) : TOT_W'(rem_sh);
        dq_d   = {dq_q[DVD_W-2:0], div_ge};
        dcnt_d = DC_W'(dcnt_q - 1'b1);
        if (dcnt_q == DC_W'(1)) state_d = pttu_pkg::ST_EMA0;
      end
      pttu_pkg::ST_EMA0: begin
        if (!started_q) begin
          rpm_d     = dq_q[23:0];
          started_d = 1'b1;
          lrpm_d    = now_q;
          state_d   = pttu_pkg::ST_DONE;
        end else begin
          state_d = pttu_pkg::ST_EMA1;
        end
      end
      pttu_pkg::ST_EMA1: begin
        acc_d   = ACC_W'(prod_q);
        state_d = pttu_pkg::ST_EMA2;
      end
      pttu_pkg::ST_EMA2: begin
        rpm_d   = (ema_sh > {2'b00, rmax_q}) ? rmax_q : ema_sh[23:0];
        lrpm_d  = now_q;
        state_d = pttu_pkg::ST_DONE;
      end
      pttu_pkg::ST_DEC0: begin
        if (rpm_q != '0 && (now_q - lrpm_q) > pttu_pkg::DECAY_TIMEOUT_MS) begin
          state_d = pttu_pkg::ST_DEC1;
        end else begin
          state_d = pttu_pkg::ST_DONE;
        end
      end
      pttu_pkg::ST_DEC1: begin
        rpm_d   = (prod_q[39:16] < pttu_pkg::DECAY_FLOOR_Q) ? '0 : prod_q[39:16];
        state_d = pttu_pkg::ST_DONE;
      end
      pttu_pkg::ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          oload   = 1'b1;
          state_d = pttu_pkg::ST_IDLE;
        end
      end
      default: state_d = pttu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (oload) ovalid_d = 1'b1;
    else if (out_o.ready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pttu_pkg::ST_IDLE;
      mdm_q <= 16'd128;   hyst_q <= 16'd256;
      tmin_q <= 23'd256;  tmax_q <= 23'd25600; tvmin_q <= 23'd512;
      alpha_q <= 16'd19661; tmo_q <= 16'd1000; rmax_q <= 24'd153600;
      prev_q <= '0; hmin_q <= '0; hmax_q <= '0;
      moving_q <= 1'b0; thr_ok_q <= 1'b0; started_q <= 1'b0;
      lmot_q <= '0; lcross_q <= '0; lrpm_q <= '0;
      pfill_q <= '0; phead_q <= '0; thr_q <= '0;
      side_q <= pttu_pkg::SIDE_UNKNOWN;
      dfill_q <= '0; dhead_q <= '0; tot_q <= '0; rpm_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q <= prev_d; hmin_q <= hmin_d; hmax_q <= hmax_d;
      moving_q <= moving_d; thr_ok_q <= thr_ok_d; started_q <= started_d;
      lmot_q <= lmot_d; lcross_q <= lcross_d; lrpm_q <= lrpm_d;
      pfill_q <= pfill_d; phead_q <= phead_d; thr_q <= thr_d; side_q <= side_d;
      dfill_q <= dfill_d; dhead_q <= dhead_d; tot_q <= tot_d; rpm_q <= rpm_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (pttu_pkg::cfg_idx_e'(cfg_idx_i))
          pttu_pkg::CFG_MOTION_DELTA_MIN:  mdm_q   <= cfg_data_i[15:0];
          pttu_pkg::CFG_MINMAX_HYST:       hyst_q  <= cfg_data_i[15:0];
          pttu_pkg::CFG_THROW_MIN:         tmin_q  <= cfg_data_i[22:0];
          pttu_pkg::CFG_THROW_MAX:         tmax_q  <= cfg_data_i[22:0];
          pttu_pkg::CFG_THROW_VALID_MIN:   tvmin_q <= cfg_data_i[22:0];
          pttu_pkg::CFG_EMA_ALPHA:         alpha_q <= cfg_data_i[15:0];
          pttu_pkg::CFG_MOTION_TIMEOUT_MS: tmo_q   <= cfg_data_i[15:0];
          pttu_pkg::CFG_RPM_MAX:           rmax_q  <= cfg_data_i;
          default: begin end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= in_i.position;
      now_q <= in_i.time_ms;
    end
    if (per_we) per_q[dhead_q] <= per_v;
    wmax_q <= wmax_d; wmin_q <= wmin_d; half_q <= half_d; cnt_q <= cnt_d;
    num_q <= num_d; dq_q <= dq_d; rem_q <= rem_d; dcnt_q <= dcnt_d;
    acc_q <= acc_d; prod_q <= prod_d;
    if (oload) begin
      orpm_q <= rpm_q; othr_q <= thr_q; ook_q <= thr_ok_q; omot_q <= moving_q;
      omin_q <= hmin_q; omax_q <= hmax_q;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.rpm          = orpm_q;
  assign out_o.throw        = othr_q;
  assign out_o.throw_ok     = ook_q;
  assign out_o.in_motion    = omot_q;
  assign out_o.min_position = omin_q;
  assign out_o.max_position = omax_q;

`ifndef ASSERT_OFF
  a_pfill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pfill_q <= PF_W'(PW)) else $error("position fill beyond depth");
  a_dfill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dfill_q <= DF_W'(PD)) else $error("period fill beyond depth");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != pttu_pkg::ST_IDLE) else $error("item dropped");
  a_rpm_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> rpm_q == '0) else $error("rpm set before first estimate");
`endif

endmodule
`default_nettype wire
